// ----- design/websocket_frame_header_parser_unit_defines.svh -----
// Assertion macros shared by the frame header parser modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef WEBSOCKET_FRAME_HEADER_PARSER_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_HEADER_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define WSFHP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define WSFHP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define WSFHP_ASSERT_SAME(lbl, ante, cons)
`define WSFHP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- design/wsfhp_pkg.sv -----
package wsfhp_pkg;

    // Parser position within a frame
    typedef enum logic [4:0] {
        PH_START = 5'd0,
        PH_LEN   = 5'd1,
        PH_EXT0  = 5'd2,
        PH_EXT1  = 5'd3,
        PH_EXT2  = 5'd4,
        PH_EXT3  = 5'd5,
        PH_EXT4  = 5'd6,
        PH_EXT5  = 5'd7,
        PH_EXT6  = 5'd8,
        PH_EXT7  = 5'd9,
        PH_KEY0  = 5'd10,
        PH_KEY1  = 5'd11,
        PH_KEY2  = 5'd12,
        PH_KEY3  = 5'd13,
        PH_DATA  = 5'd14,
        PH_ERR   = 5'd15
    } phase_t;

    typedef enum logic [1:0] {
        EV_HDR  = 2'd0,
        EV_DONE = 2'd1,
        EV_PAY  = 2'd2,
        EV_ERR  = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_OPCODE = 2'd1,
        ERR_ZERO   = 2'd2
    } err_t;

    // Frame opcodes accepted by the parser
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    // Seven-bit length code that selects the 16-bit extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;

    typedef struct packed {
        event_t      ev;
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] length;
        logic [31:0] key;
        logic [7:0]  pay;
        logic        last;
        err_t        err;
    } result_t;

endpackage

// ----- design/wsfhp_core.sv -----
`include "websocket_frame_header_parser_unit_defines.svh"

module wsfhp_core
    import wsfhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_reg, mask_next;
    logic        short_reg, short_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] left_reg, left_next;
    err_t        err_reg, err_next;

    event_t      ev;
    logic [7:0]  pay;
    logic        last;
    logic        len_done;
    logic        op_known;

    assign op_known = (data_byte[3:0] == OP_CONT) || (data_byte[3:0] == OP_TEXT) ||
                      (data_byte[3:0] == OP_BIN) || (data_byte[3:0] == OP_CLOSE) ||
                      (data_byte[3:0] == OP_PING) || (data_byte[3:0] == OP_PONG);

    // Advance the parser by one stream word
    always_comb
    begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        short_next  = short_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        left_next   = left_reg;
        err_next    = err_reg;
        ev          = EV_HDR;
        pay         = 8'd0;
        last        = 1'b0;
        len_done    = 1'b0;

        case (phase_reg)
            PH_ERR:
            begin
                ev = EV_ERR;
            end
            PH_START:
            begin
                fin_next    = data_byte[7];
                opcode_next = data_byte[3:0];
                mask_next   = 1'b0;
                short_next  = 1'b0;
                len_next    = 64'd0;
                key_next    = 32'd0;
                left_next   = 64'd0;
                if (data_byte[6:4] != 3'd0 || !op_known)
                begin
                    err_next   = ERR_OPCODE;
                    phase_next = PH_ERR;
                    ev         = EV_ERR;
                end
                else
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                mask_next = data_byte[7];
                if (data_byte[6:0] < LEN_EXT16)
                begin
                    len_next = {57'd0, data_byte[6:0]};
                    len_done = 1'b1;
                end
                else
                begin
                    short_next = (data_byte[6:0] == LEN_EXT16);
                    phase_next = PH_EXT0;
                end
            end
            PH_EXT0, PH_EXT1, PH_EXT2, PH_EXT3, PH_EXT4, PH_EXT5, PH_EXT6, PH_EXT7:
            begin
                len_next = {len_reg[55:0], data_byte};
                if (phase_reg == PH_EXT7 || (short_reg && phase_reg == PH_EXT1))
                    len_done = 1'b1;
                else
                    phase_next = phase_t'(phase_reg + 5'd1);
            end
            PH_KEY0, PH_KEY1, PH_KEY2, PH_KEY3:
            begin
                key_next = {key_reg[23:0], data_byte};
                if (phase_reg == PH_KEY3)
                begin
                    phase_next = PH_DATA;
                    ev         = EV_DONE;
                end
                else
                begin
                    phase_next = phase_t'(phase_reg + 5'd1);
                end
            end
            PH_DATA:
            begin
                ev  = EV_PAY;
                pay = data_byte;
                if (left_reg[63:1] == 63'd0)
                begin
                    last       = 1'b1;
                    left_next  = 64'd0;
                    phase_next = PH_START;
                end
                else
                begin
                    left_next = left_reg - 64'd1;
                end
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase

        // Check the final length, then enter the key or the payload
        if (len_done)
        begin
            if (len_next == 64'd0)
            begin
                err_next   = ERR_ZERO;
                phase_next = PH_ERR;
                ev         = EV_ERR;
            end
            else
            begin
                left_next = len_next;
                if (mask_next)
                begin
                    phase_next = PH_KEY0;
                end
                else
                begin
                    phase_next = PH_DATA;
                    ev         = EV_DONE;
                end
            end
        end
    end

    // Build the result word from the updated state
    always_comb
    begin
        res.ev     = ev;
        res.fin    = fin_next;
        res.opcode = opcode_next;
        res.masked = mask_next;
        res.length = len_next;
        res.key    = key_next;
        res.pay    = pay;
        res.last   = last;
        res.err    = (ev == EV_ERR) ? err_next : ERR_NONE;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            short_reg <= 1'b0;
            left_reg  <= 64'd0;
            err_reg   <= ERR_NONE;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            short_reg <= short_next;
            left_reg  <= left_next;
            err_reg   <= err_next;
        end
    end

    // Hold header fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg    <= 1'b0;
            opcode_reg <= 4'd0;
            mask_reg   <= 1'b0;
            len_reg    <= 64'd0;
            key_reg    <= 32'd0;
        end
        else if (step)
        begin
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
        end
    end

    `WSFHP_ASSERT_NEXT(a_err_sticky, phase_reg == PH_ERR, phase_reg == PH_ERR)
    `WSFHP_ASSERT_SAME(a_err_phase, err_reg != ERR_NONE, phase_reg == PH_ERR)
    `WSFHP_ASSERT_SAME(a_err_code, step && ev == EV_ERR, res.err != ERR_NONE)
    `WSFHP_ASSERT_NEXT(a_last_restart, step && last, phase_reg == PH_START)

endmodule

// ----- design/wsfhp_out_stage.sv -----
module wsfhp_out_stage
    import wsfhp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  logic    take,
    input  result_t res_in,
    output logic    valid,
    output result_t res_out
);

    logic    valid_reg;
    result_t res_reg;

    // Track whether a result word is waiting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (take)
            valid_reg <= 1'b0;
    end

    // Capture the result word
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

    assign valid   = valid_reg;
    assign res_out = res_reg;

endmodule

// ----- design/websocket_frame_header_parser_unit.sv -----
// WebSocket frame header parser. One stream byte enters per accepted word and
// produces exactly one result word, captured in the output register when the
// byte is accepted. Throughput is one byte per cycle while in_ready is high;
// in_ready stays high as long as the output register is empty or
// is being drained in the same cycle. Header fields, length and mask key are
// reported as accumulated so far; payload bytes pass through raw with a last
// flag, after which the parser expects a new frame. An unknown opcode, a set
// reserved bit or a zero length latches an error until reset.
module websocket_frame_header_parser_unit
    import wsfhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_res,
    output logic        fin_flag,
    output logic [3:0]  frame_opcode,
    output logic        masked,
    output logic [63:0] frame_length,
    output logic [31:0] mask_key,
    output logic [7:0]  payload_byte,
    output logic        last_payload,
    output logic [1:0]  error_code
);

    logic    step;
    result_t res;
    result_t res_q;

    // Accept a word whenever the output register can take its result
    assign in_ready = !out_valid || out_ready;
    assign step     = in_valid && in_ready;

    wsfhp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (data_byte),
        .res       (res)
    );

    wsfhp_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (step),
        .take    (out_ready),
        .res_in  (res),
        .valid   (out_valid),
        .res_out (res_q)
    );

    assign event_res    = res_q.ev;
    assign fin_flag     = res_q.fin;
    assign frame_opcode = res_q.opcode;
    assign masked       = res_q.masked;
    assign frame_length = res_q.length;
    assign mask_key     = res_q.key;
    assign payload_byte = res_q.pay;
    assign last_payload = res_q.last;
    assign error_code   = res_q.err;

endmodule

// ----- sim/tb_websocket_frame_header_parser_unit.sv -----
`timescale 1ns / 1ps

module tb_websocket_frame_header_parser_unit;
    import wsfhp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned MAX_REPORTS = 10;
    localparam logic [7:0]  RSV_MASK    = 8'h70;
    localparam logic [6:0]  LEN_EXT64   = 7'd127;

    typedef enum logic [1:0] {
        LF_SHORT,
        LF_EXT16,
        LF_EXT64
    } len_form_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  event_res;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        masked;
    logic [63:0] frame_length;
    logic [31:0] mask_key;
    logic [7:0]  payload_byte;
    logic        last_payload;
    logic [1:0]  error_code;

    // Parser state mirrored by the predictor
    phase_t      ph = PH_START;
    logic        h_fin = 1'b0;
    logic [3:0]  h_op = 4'h0;
    logic        h_mask = 1'b0;
    logic        short_ext = 1'b0;
    logic [63:0] len_acc = '0;
    logic [31:0] key_acc = '0;
    logic [63:0] left = '0;
    err_t        err_lat = ERR_NONE;

    result_t     parser_words[$];
    logic [3:0]  known_ops[6] = '{OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG};

    int unsigned send_pct = 0;
    int unsigned recv_pct = 0;
    int unsigned hold_left = 0;
    int unsigned cycles = 0;
    int unsigned bytes_sent = 0;
    int unsigned words_checked = 0;
    int unsigned frames_sent = 0;
    int unsigned fail_count = 0;
    string       tail_case = "none";

    websocket_frame_header_parser_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_res    (event_res),
        .fin_flag     (fin_flag),
        .frame_opcode (frame_opcode),
        .masked       (masked),
        .frame_length (frame_length),
        .mask_key     (mask_key),
        .payload_byte (payload_byte),
        .last_payload (last_payload),
        .error_code   (error_code)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic is_frame_opcode(input logic [3:0] op);
        return op == OP_CONT || op == OP_TEXT || op == OP_BIN ||
               op == OP_CLOSE || op == OP_PING || op == OP_PONG;
    endfunction

    function automatic event_t latch_error(input err_t code);
        err_lat = code;
        ph = PH_ERR;
        return EV_ERR;
    endfunction

    // Length is final: reject zero, then go to the key or the payload
    function automatic event_t close_length();
        if (len_acc == 64'd0)
            return latch_error(ERR_ZERO);
        left = len_acc;
        if (h_mask)
        begin
            ph = PH_KEY0;
            return EV_HDR;
        end
        ph = PH_DATA;
        return EV_DONE;
    endfunction

    // Advance the parser by one byte and return the word it should emit
    function automatic result_t parse_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        r.ev = EV_HDR;
        if (ph == PH_ERR)
        begin
            r.ev = EV_ERR;
        end
        else if (ph == PH_START)
        begin
            h_fin = b[7];
            h_op = b[3:0];
            h_mask = 1'b0;
            short_ext = 1'b0;
            len_acc = '0;
            key_acc = '0;
            left = '0;
            if ((b & RSV_MASK) != 8'h00 || !is_frame_opcode(h_op))
                r.ev = latch_error(ERR_OPCODE);
            else
                ph = PH_LEN;
        end
        else if (ph == PH_LEN)
        begin
            h_mask = b[7];
            if (b[6:0] < LEN_EXT16)
            begin
                len_acc = {57'd0, b[6:0]};
                r.ev = close_length();
            end
            else
            begin
                short_ext = (b[6:0] == LEN_EXT16);
                ph = PH_EXT0;
            end
        end
        else if (ph >= PH_EXT0 && ph <= PH_EXT7)
        begin
            len_acc = {len_acc[55:0], b};
            if (ph == PH_EXT7 || (short_ext && ph == PH_EXT1))
                r.ev = close_length();
            else
                ph = phase_t'(ph + 5'd1);
        end
        else if (ph >= PH_KEY0 && ph <= PH_KEY3)
        begin
            key_acc = {key_acc[23:0], b};
            if (ph == PH_KEY3)
            begin
                ph = PH_DATA;
                r.ev = EV_DONE;
            end
            else
            begin
                ph = phase_t'(ph + 5'd1);
            end
        end
        else
        begin
            r.ev = EV_PAY;
            r.pay = b;
            if (left <= 64'd1)
            begin
                r.last = 1'b1;
                left = '0;
                ph = PH_START;
            end
            else
            begin
                left = left - 64'd1;
            end
        end
        r.fin = h_fin;
        r.opcode = h_op;
        r.masked = h_mask;
        r.length = len_acc;
        r.key = key_acc;
        r.err = (r.ev == EV_ERR) ? err_lat : ERR_NONE;
        return r;
    endfunction

    // Offer one word after a random gap, hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        parser_words.push_back(parse_byte(b));
        bytes_sent++;
    endtask

    task automatic send_frame(input logic fin, input logic [3:0] op, input logic msk,
                              input len_form_t form, input logic [63:0] len,
                              input logic [31:0] key);
        int          i;
        logic [63:0] n;
        send_byte({fin, 3'b000, op});
        case (form)
            LF_SHORT:
                send_byte({msk, len[6:0]});
            LF_EXT16:
            begin
                send_byte({msk, LEN_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default:
            begin
                send_byte({msk, LEN_EXT64});
                for (i = 7; i >= 0; i--)
                    send_byte(len[i*8 +: 8]);
            end
        endcase
        if (msk)
            for (i = 3; i >= 0; i--)
                send_byte(key[i*8 +: 8]);
        for (n = 64'd0; n < len; n++)
            send_byte(8'($urandom_range(0, 255)));
        frames_sent++;
    endtask

    // Mostly short lengths; non-minimal extended forms are common on purpose
    task automatic send_random_frame();
        len_form_t   form;
        logic [63:0] len;
        int unsigned r;
        r = $urandom_range(0, 9);
        form = (r < 6) ? LF_SHORT : (r < 8) ? LF_EXT16 : LF_EXT64;
        r = $urandom_range(0, 19);
        case (form)
            LF_SHORT:
                len = (r == 0) ? 64'd125 :
                      (r < 4) ? 64'($urandom_range(7, 40)) : 64'($urandom_range(1, 6));
            LF_EXT16:
                len = (r < 2) ? 64'($urandom_range(126, 300)) : 64'($urandom_range(1, 6));
            default:
                len = 64'($urandom_range(1, 4));
        endcase
        send_frame(1'($urandom_range(0, 1)), known_ops[$urandom_range(0, 5)],
                   1'($urandom_range(0, 1)), form, len, 32'($urandom()));
    endtask

    task automatic test_directed_frames();
        send_frame(1'b1, OP_TEXT, 1'b0, LF_SHORT, 64'd1, 32'h0);
        send_frame(1'b0, OP_CONT, 1'b1, LF_EXT16, 64'd2, 32'hFFFF_FFFF);
        send_frame(1'b1, OP_PONG, 1'b0, LF_EXT64, 64'd1, 32'h0);
    endtask

    task automatic test_random_frames(input int unsigned byte_target);
        while (bytes_sent < byte_target)
            send_random_frame();
    endtask

    // Stall the output side long enough that the input side backs up
    task automatic test_backpressure();
        int unsigned saved_pct;
        saved_pct = send_pct;
        send_pct = 0;
        hold_left = 300;
        send_frame(1'b1, OP_BIN, 1'b1, LF_SHORT, 64'd24, 32'h0F1E_2D3C);
        send_random_frame();
        send_pct = saved_pct;
    endtask

    // Terminal case: an error latch or an endless payload; only one per run
    task automatic test_stream_end();
        int unsigned pick;
        int          i;
        logic [7:0]  first;
        logic [3:0]  op;
        logic        msk;
        pick = $urandom_range(0, 5);
        msk = 1'($urandom_range(0, 1));
        first = {1'($urandom_range(0, 1)), 3'b000, known_ops[$urandom_range(0, 5)]};
        case (pick)
            0:
            begin
                tail_case = "unknown opcode";
                do
                    op = 4'($urandom_range(0, 15));
                while (is_frame_opcode(op));
                send_byte({first[7], 3'b000, op});
            end
            1:
            begin
                tail_case = "reserved bit set";
                send_byte({first[7], 3'($urandom_range(1, 7)), first[3:0]});
            end
            2:
            begin
                tail_case = "zero 7-bit length";
                send_byte(first);
                send_byte({msk, 7'd0});
            end
            3:
            begin
                tail_case = "zero 16-bit length";
                send_byte(first);
                send_byte({msk, LEN_EXT16});
                repeat (2) send_byte(8'h00);
            end
            4:
            begin
                tail_case = "zero 64-bit length";
                send_byte(first);
                send_byte({msk, LEN_EXT64});
                repeat (8) send_byte(8'h00);
            end
            default:
            begin
                tail_case = "64-bit length with top bit set";
                send_byte(first);
                send_byte({msk, LEN_EXT64});
                send_byte(8'h80 | 8'($urandom_range(0, 255)));
                repeat (7) send_byte(8'($urandom_range(0, 255)));
                if (msk)
                    repeat (4) send_byte(8'($urandom_range(0, 255)));
            end
        endcase
        // Bytes after the terminal case: latched error or endless payload
        for (i = 0; i < 12; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic flag_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (fail_count < MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h",
                     $realtime, field, want, got);
        fail_count++;
    endtask

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
            flag_mismatch(field, want, got);
    endtask

    task automatic check_word();
        result_t want;
        if (parser_words.size() == 0)
        begin
            flag_mismatch("unexpected word, event_res", 64'd0, 64'(event_res));
            return;
        end
        want = parser_words.pop_front();
        words_checked++;
        compare_field("event_res", 64'(want.ev), 64'(event_res));
        compare_field("fin_flag", 64'(want.fin), 64'(fin_flag));
        compare_field("frame_opcode", 64'(want.opcode), 64'(frame_opcode));
        compare_field("masked", 64'(want.masked), 64'(masked));
        compare_field("frame_length", want.length, frame_length);
        compare_field("mask_key", 64'(want.key), 64'(mask_key));
        compare_field("payload_byte", 64'(want.pay), 64'(payload_byte));
        compare_field("last_payload", 64'(want.last), 64'(last_payload));
        compare_field("error_code", 64'(want.err), 64'(error_code));
    endtask

    // Check each accepted word, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_word();
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words pending", cycles,
                     parser_words.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pct = 27;
        recv_pct = 55;
        test_directed_frames();
        test_random_frames(160);
        test_backpressure();

        send_pct = 55;
        recv_pct = 27;
        test_random_frames(310);

        send_pct = 0;
        recv_pct = 0;
        test_random_frames(450);
        test_stream_end();
        in_valid <= 1'b0;

        // Drain, then give the output register time to show stray words
        recv_pct = 0;
        while (parser_words.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("Sent %0d bytes in %0d well-formed frames, checked %0d result words",
                 bytes_sent, frames_sent, words_checked);
        $display("Stream ended with: %s; mismatches: %0d", tail_case, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
